FILE: design/sgm_pkg.sv
package sgm_pkg;

  localparam int unsigned MaxPatternDefault = 32;

  localparam logic [7:0] StarByte = 8'd42;
  localparam logic [7:0] DotByte  = 8'd46;

  localparam int unsigned CharW = 8;
  localparam int unsigned SlotW = 5;
  localparam int unsigned LenW  = 6;
  // wide enough to compare any position 0..64 against a length
  localparam int unsigned PosW  = 7;

  typedef enum logic [1:0] {
    OP_LOAD = 2'd0,
    OP_NAME = 2'd1,
    OP_END  = 2'd2,
    OP_NONE = 2'd3
  } sgm_op_e;

  // request decoded for the matcher core
  typedef struct packed {
    logic step;    // name character
    logic finish;  // end of name
    logic is_dot;  // character is '.'
  } sgm_ctl_t;

endpackage

FILE: design/sgm_store.sv
module sgm_store import sgm_pkg::*; #(
  parameter int unsigned MaxPattern = MaxPatternDefault
) (
  input  logic                  clk_i,
  input  logic                  we_i,
  input  logic [SlotW-1:0]      slot_i,
  input  logic [CharW-1:0]      char_i,
  output logic [MaxPattern-1:0] star_o,
  output logic [MaxPattern-1:0] eq_o
);

  logic [CharW-1:0] byte_q [MaxPattern];
  logic [PosW-1:0]  slot_ext;

  assign slot_ext = PosW'(slot_i);

  // slots at or beyond the store size never decode, so such loads drop
  always_ff @(posedge clk_i) begin
    for (int p = 0; p < MaxPattern; p++) begin
      if (we_i && (slot_ext == PosW'(p))) begin
        byte_q[p] <= char_i;
      end
    end
  end

  always_comb begin
    for (int p = 0; p < MaxPattern; p++) begin
      star_o[p] = (byte_q[p] == StarByte);
      eq_o[p]   = (byte_q[p] == char_i);
    end
  end

endmodule

FILE: design/sgm_nfa.sv
module sgm_nfa import sgm_pkg::*; #(
  parameter int unsigned MaxPattern = MaxPatternDefault
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  sgm_ctl_t              ctl_i,
  input  logic [LenW-1:0]       len_i,
  input  logic [MaxPattern-1:0] star_i,
  input  logic [MaxPattern-1:0] eq_i,
  output logic                  hit_o
);

  localparam int unsigned NumPos = MaxPattern + 1;
  localparam int unsigned Steps  = (NumPos > 1) ? $clog2(NumPos) : 1;

  logic [NumPos-1:0]     active_q, active_d;
  logic                  started_q, started_d;
  logic                  lead_q, lead_d;

  logic [MaxPattern-1:0] mask;
  logic [MaxPattern-1:0] prop;
  logic [NumPos-1:0]     sel;
  logic [NumPos-1:0]     cur_cl;
  logic [NumPos-1:0]     nxt_raw;
  logic [NumPos-1:0]     nxt_cl;
  logic [MaxPattern-1:0] live;
  logic [PosW-1:0]       len_ext;
  logic [PosW-1:0]       eff_len;
  logic                  all_star;

  // Star closure as a parallel prefix: a star at an active position
  // activates the next one, and runs of stars chain along.
  function automatic logic [NumPos-1:0] close_set(
    input logic [NumPos-1:0]     set,
    input logic [MaxPattern-1:0] pr
  );
    logic [NumPos-1:0] g;
    logic [NumPos-1:0] a;
    g = set;
    a = {pr, 1'b0};
    for (int s = 0; s < Steps; s++) begin
      g = g | (a & (g << (1 << s)));
      a = a & (a << (1 << s));
    end
    return g;
  endfunction

  assign len_ext = PosW'(len_i);
  assign eff_len = (len_ext > PosW'(MaxPattern)) ? PosW'(MaxPattern) : len_ext;

  always_comb begin
    for (int p = 0; p < MaxPattern; p++) begin
      mask[p] = (PosW'(p) < len_ext);
    end
    for (int i = 0; i < NumPos; i++) begin
      sel[i] = (PosW'(i) == eff_len);
    end
  end

  assign prop     = star_i & mask;
  assign all_star = &(star_i | ~mask);

  assign cur_cl  = close_set(active_q, prop);
  assign live    = cur_cl[MaxPattern-1:0] & mask;
  assign nxt_raw = {1'b0, live & star_i} | {live & ~star_i & eq_i, 1'b0};
  assign nxt_cl  = close_set(nxt_raw, prop);

  assign hit_o = all_star ? !lead_q : |(cur_cl & sel);

  always_comb begin
    active_d  = active_q;
    started_d = started_q;
    lead_d    = lead_q;
    if (ctl_i.finish) begin
      active_d  = NumPos'(1);
      started_d = 1'b0;
      lead_d    = 1'b0;
    end else if (ctl_i.step) begin
      active_d = nxt_cl;
      if (!started_q) begin
        started_d = 1'b1;
        lead_d    = ctl_i.is_dot;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q  <= NumPos'(1);
      started_q <= 1'b0;
      lead_q    <= 1'b0;
    end else begin
      active_q  <= active_d;
      started_q <= started_d;
      lead_q    <= lead_d;
    end
  end

endmodule

FILE: design/star_glob_matcher_top.sv
// Channel | Valid / stall            | Payload
// --------+--------------------------+--------------------------------------
// in      | in_valid_i / in_stall_o  | in_operation_i, in_slot_i,
//         |                          | in_character_i
// out     | out_valid_o / out_stall_i| out_matched_o
// cfg     | cfg_we_i (no stall)      | cfg_data_i (pattern length)
//
// One request is taken per cycle while in_stall_o is low; an end-of-name
// request moves from the input register to the result register when it
// advances, and its result is offered from the result register.
// The per-cycle figure is set by the active-position vector, which is
// updated for all pattern positions at once in the execute stage.
// Reset clears the valids, the length register and the matcher state; the
// pattern bytes stay unknown until loaded.
// A stalled result holds; the input register keeps taking requests until an
// end-of-name request in it finds the result register still full.
module star_glob_matcher_top import sgm_pkg::*; #(
  parameter int unsigned MaxPattern = MaxPatternDefault
) (
  input  logic             clk_i,
  input  logic             rst_ni,

  input  logic             cfg_we_i,
  input  logic [LenW-1:0]  cfg_data_i,

  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [1:0]       in_operation_i,
  input  logic [SlotW-1:0] in_slot_i,
  input  logic [CharW-1:0] in_character_i,

  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic             out_matched_o
);

  logic [LenW-1:0]       len_q;

  // input register
  logic                  s1_valid_q;
  sgm_op_e               s1_op_q;
  logic [SlotW-1:0]      s1_slot_q;
  logic [CharW-1:0]      s1_char_q;

  // result register
  logic                  out_valid_q;
  logic                  out_matched_q;

  logic                  s1_adv;
  logic                  s1_load;
  logic                  out_free;
  logic                  store_we;
  sgm_ctl_t              ctl;
  logic [MaxPattern-1:0] star_vec;
  logic [MaxPattern-1:0] eq_vec;
  logic                  hit;

  // Only end-of-name requests need room in the result register.
  assign out_free   = !out_valid_q || !out_stall_i;
  assign s1_adv     = s1_valid_q && ((s1_op_q != OP_END) || out_free);
  assign in_stall_o = s1_valid_q && !s1_adv;
  assign s1_load    = in_valid_i && !in_stall_o;

  // Decode the held request; nothing happens unless it advances this cycle.
  always_comb begin
    store_we   = 1'b0;
    ctl.step   = 1'b0;
    ctl.finish = 1'b0;
    ctl.is_dot = (s1_char_q == DotByte);
    case (s1_op_q)
      OP_LOAD: store_we   = s1_adv;
      OP_NAME: ctl.step   = s1_adv;
      OP_END:  ctl.finish = s1_adv;
      default: ;
    endcase
  end

  sgm_store #(
    .MaxPattern(MaxPattern)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (store_we),
    .slot_i (s1_slot_q),
    .char_i (s1_char_q),
    .star_o (star_vec),
    .eq_o   (eq_vec)
  );

  sgm_nfa #(
    .MaxPattern(MaxPattern)
  ) u_nfa (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (ctl),
    .len_i  (len_q),
    .star_i (star_vec),
    .eq_i   (eq_vec),
    .hit_o  (hit)
  );

  // Control: length register, stage valids.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q       <= '0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        len_q <= cfg_data_i;
      end
      if (s1_load) begin
        s1_valid_q <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
      if (ctl.finish) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload: capture new requests, hold results until taken.
  always_ff @(posedge clk_i) begin
    if (s1_load) begin
      s1_op_q   <= sgm_op_e'(in_operation_i);
      s1_slot_q <= in_slot_i;
      s1_char_q <= in_character_i;
    end
    if (ctl.finish) begin
      out_matched_q <= hit;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_matched_o = out_matched_q;

endmodule

FILE: sim/tb_star_glob_matcher_top.sv
`timescale 1ns / 100ps

module tb_star_glob_matcher_top;
  import sgm_pkg::*;

  localparam int unsigned MaxPat     = MaxPatternDefault;
  localparam int unsigned HoldCycles = 300;
  localparam int unsigned CycleLimit = 200000;

  localparam logic [7:0] ChA = 8'h61;
  localparam logic [7:0] ChB = 8'h62;

  // One request as it goes over the input channel.
  typedef struct packed {
    sgm_op_e          op;
    logic [SlotW-1:0] slot;
    logic [CharW-1:0] ch;
  } glob_req_t;

  logic             clk_i;
  logic             rst_ni         = 1'b0;
  logic             cfg_we_i       = 1'b0;
  logic [LenW-1:0]  cfg_data_i     = '0;
  logic             in_valid_i     = 1'b0;
  logic             in_stall_o;
  logic [1:0]       in_operation_i = OP_NONE;
  logic [SlotW-1:0] in_slot_i      = '0;
  logic [CharW-1:0] in_character_i = '0;
  logic             out_valid_o;
  logic             out_stall_i    = 1'b0;
  logic             out_matched_o;

  star_glob_matcher_top dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .in_operation_i (in_operation_i),
    .in_slot_i      (in_slot_i),
    .in_character_i (in_character_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .out_matched_o  (out_matched_o)
  );

  // Requests waiting for the driver, and match bits still owed by the block.
  glob_req_t   pending_q [$];
  bit          due_verdicts [$];

  // Shadow copy of the matcher: pattern bytes, length register, active set.
  logic [7:0]      pat_mem [MaxPat];
  logic [LenW-1:0] len_reg = '0;
  logic [MaxPat:0] live_pos = {{MaxPat{1'b0}}, 1'b1};
  bit              name_open = 1'b0;
  bit              dot_first = 1'b0;

  // Pattern as the stimulus side last loaded it; used to build likely matches.
  logic [7:0]  plan [MaxPat];
  int unsigned plan_len = 0;

  int unsigned sent_count = 0;
  int unsigned err_count  = 0;
  int unsigned cycle_count = 0;
  int unsigned hold_asks = 0;
  int unsigned hold_seen = 0;
  int unsigned hold_left = 0;
  int unsigned stall_pct = 0;
  int unsigned stall_run = 0;
  int unsigned burst_left = 0;
  int unsigned gap_left = 0;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) cycle_count <= cycle_count + 1;

  // Stop a hung run: the handshakes below never wait on a fixed count.
  initial begin
    wait (cycle_count >= CycleLimit);
    $display("FAIL star_glob_matcher_top");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  // Propagate through stars: an active star also makes the next position active.
  // Walk upward so that a run of stars chains in one pass.
  function automatic logic [MaxPat:0] star_close(input logic [MaxPat:0] set,
                                                 input int unsigned n);
    logic [MaxPat:0] res;
    res = set;
    for (int unsigned p = 0; p < n; p++)
      if (res[p] && pat_mem[p] == StarByte) res[p+1] = 1'b1;
    return res;
  endfunction

  // Advance the shadow matcher by one accepted request; queue the match bit
  // for an end of name.
  task automatic track_request(input sgm_op_e op, input logic [SlotW-1:0] slot,
                               input logic [CharW-1:0] ch);
    int unsigned     n;
    logic [MaxPat:0] nxt;
    bit              hit;
    bit              only_stars;
    n = (len_reg > MaxPat) ? MaxPat : len_reg;
    case (op)
      // slot is five bits wide, so it always lands inside the store
      OP_LOAD: pat_mem[slot] = ch;
      OP_NAME: begin
        if (!name_open) begin
          name_open = 1'b1;
          dot_first = (ch == DotByte);
        end
        live_pos = star_close(live_pos, n);
        nxt = '0;
        for (int unsigned p = 0; p < n; p++) begin
          if (live_pos[p]) begin
            if (pat_mem[p] == StarByte) nxt[p] = 1'b1;
            else if (pat_mem[p] == ch) nxt[p+1] = 1'b1;
          end
        end
        live_pos = star_close(nxt, n);
      end
      OP_END: begin
        only_stars = 1'b1;
        for (int unsigned p = 0; p < n; p++)
          if (pat_mem[p] != StarByte) only_stars = 1'b0;
        // an empty or all-star pattern hides dot names and takes the rest
        if (only_stars) begin
          hit = !dot_first;
        end else begin
          live_pos = star_close(live_pos, n);
          hit = live_pos[n];
        end
        due_verdicts.push_back(hit);
        live_pos  = {{MaxPat{1'b0}}, 1'b1};
        name_open = 1'b0;
        dot_first = 1'b0;
      end
      default: ;  // unused code: drop it
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Request driver: bursts of random length separated by random gaps
  // ---------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    glob_req_t next_req;
    if (!rst_ni) begin
      in_valid_i     <= 1'b0;
      in_operation_i <= OP_NONE;
      in_slot_i      <= '0;
      in_character_i <= '0;
      burst_left = 0;
      gap_left   = 0;
    end else begin
      // Feed the request the block takes at this edge to the shadow matcher.
      if (in_valid_i && !in_stall_o)
        track_request(sgm_op_e'(in_operation_i), in_slot_i, in_character_i);
      // Hold a stalled request; otherwise advance to the next one or idle.
      if (!in_valid_i || !in_stall_o) begin
        if (gap_left != 0) begin
          gap_left--;
          in_valid_i <= 1'b0;
        end else if (pending_q.size() != 0) begin
          next_req = pending_q.pop_front();
          in_valid_i     <= 1'b1;
          in_operation_i <= next_req.op;
          in_slot_i      <= next_req.slot;
          in_character_i <= next_req.ch;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 24);
            gap_left   = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 6);
          end
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result stall: random duty cycle redrawn after each random-length run, plus
  // a long hold when the stimulus asks for one
  // ---------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      hold_left = 0;
      stall_run = 0;
    end else begin
      if (hold_seen != hold_asks) begin
        hold_seen = hold_asks;
        hold_left = HoldCycles;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        if (stall_run == 0) begin
          case ($urandom_range(0, 3))
            0:       stall_pct = 0;
            1:       stall_pct = 20;
            2:       stall_pct = 50;
            default: stall_pct = 85;
          endcase
          stall_run = $urandom_range(16, 80);
        end
        stall_run--;
        out_stall_i <= ($urandom_range(0, 99) < stall_pct);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result monitor
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(input string what, input logic got, input logic want);
    err_count++;
    $display("ERROR at %0t: %s: matched=%b, predicted %b", $time, what, got, want);
  endtask

  always @(posedge clk_i) begin
    bit want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (due_verdicts.size() == 0) begin
        report_mismatch("result with no name pending", out_matched_o, 1'bx);
      end else begin
        want = due_verdicts.pop_front();
        if (out_matched_o !== want)
          report_mismatch("wrong match bit", out_matched_o, want);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  task automatic push_req(input sgm_op_e op, input logic [SlotW-1:0] slot,
                          input logic [CharW-1:0] ch);
    glob_req_t r;
    r.op   = op;
    r.slot = slot;
    r.ch   = ch;
    pending_q.push_back(r);
    if (op != OP_NONE) sent_count++;
  endtask

  // Stream a name given as text, then close it.
  task automatic push_word(input string s);
    for (int i = 0; i < s.len(); i++)
      push_req(OP_NAME, SlotW'($urandom_range(0, 31)), s[i]);
    push_req(OP_END, SlotW'($urandom_range(0, 31)), CharW'($urandom_range(0, 255)));
  endtask

  // Write the pattern length; only called while the block is idle.
  task automatic write_len(input int unsigned v);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_data_i <= LenW'(v);
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    len_reg = LenW'(v);
  endtask

  // Wait until every request is taken and every match bit is back, then let
  // the pipeline settle past any trailing load or name byte.
  task automatic drain();
    while (pending_q.size() != 0 || in_valid_i || due_verdicts.size() != 0)
      @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Mostly a small alphabet so that names and patterns meet; sometimes any byte.
  function automatic logic [7:0] name_byte();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 3) return ChA;
    if (r < 5) return ChB;
    if (r < 7) return DotByte;
    if (r == 7) return StarByte;
    return CharW'($urandom_range(0, 255));
  endfunction

  task automatic load_pattern(input int unsigned n);
    logic [7:0] b;
    for (int unsigned k = 0; k < n; k++) begin
      b = ($urandom_range(0, 99) < 35) ? StarByte : name_byte();
      plan[k] = b;
      push_req(OP_LOAD, SlotW'(k), b);
    end
    plan_len = n;
  endtask

  // Build one name, usually by filling the stars of the planned pattern and
  // sometimes breaking one byte; else a short random name. Sprinkle in unused
  // codes and loads that land mid-name.
  task automatic send_name();
    logic [7:0]  word [$];
    logic [7:0]  b;
    int unsigned k;
    if ($urandom_range(0, 3) != 0) begin
      for (k = 0; k < plan_len; k++) begin
        if (plan[k] == StarByte) repeat ($urandom_range(0, 3)) word.push_back(name_byte());
        else word.push_back(plan[k]);
      end
      if ($urandom_range(0, 4) == 0 && word.size() != 0)
        word[$urandom_range(0, word.size() - 1)] = name_byte();
    end else begin
      repeat ($urandom_range(0, 6)) word.push_back(name_byte());
    end
    foreach (word[i]) begin
      case ($urandom_range(0, 39))
        0: push_req(OP_NONE, SlotW'($urandom_range(0, 31)), CharW'($urandom_range(0, 255)));
        1: begin
          k = $urandom_range(0, MaxPat - 1);
          b = CharW'($urandom_range(0, 255));
          plan[k] = b;
          push_req(OP_LOAD, SlotW'(k), b);
        end
        default: ;
      endcase
      push_req(OP_NAME, SlotW'($urandom_range(0, 31)), word[i]);
    end
    push_req(OP_END, SlotW'($urandom_range(0, 31)), CharW'($urandom_range(0, 255)));
  endtask

  initial begin
    int unsigned new_len;
    int unsigned phase;

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Empty pattern: the store is never read, dot names are rejected.
    write_len(0);
    push_req(OP_END, '0, '0);
    push_word(".");
    push_word("a.");
    push_req(OP_NONE, 5'd31, 8'hFF);
    push_word("b");
    drain();

    // Fill every slot with a star, then use the longest length code.
    for (int unsigned k = 0; k < MaxPat; k++) push_req(OP_LOAD, SlotW'(k), StarByte);
    drain();
    write_len(63);
    push_req(OP_END, '0, '0);
    push_word(".a");
    push_word("xy");
    // Last position literal: the all-star rule no longer applies.
    push_req(OP_LOAD, 5'd31, ChA);
    push_word("ba");
    push_word("b");
    // Swap the last byte while a name is open; progress is kept.
    push_req(OP_NAME, 5'd7, "z");
    push_req(OP_LOAD, 5'd31, "z");
    push_req(OP_END, 5'd0, 8'h00);
    push_word("z");
    drain();

    // Literal dot at the head of a pattern does match a dot name.
    write_len(2);
    push_req(OP_LOAD, 5'd0, DotByte);
    push_req(OP_LOAD, 5'd1, ChA);
    push_word(".a");
    push_word(".b");
    push_req(OP_END, 5'd31, 8'hFF);
    drain();

    // Byte extremes.
    write_len(1);
    push_req(OP_LOAD, 5'd0, 8'hFF);
    push_req(OP_NAME, 5'd0, 8'hFF);
    push_req(OP_END, 5'd0, 8'h00);
    push_req(OP_NAME, 5'd31, 8'h00);
    push_req(OP_END, 5'd31, 8'hFF);
    drain();

    // Full pattern length exactly at the store size.
    write_len(MaxPat);
    push_req(OP_NAME, 5'd3, 8'hFF);
    push_word("aqz");
    drain();

    // Random phases: new length and pattern, then a batch of names.
    phase = 0;
    while (sent_count < 360) begin
      case ($urandom_range(0, 9))
        0:       new_len = 0;
        1:       new_len = MaxPat;
        2:       new_len = $urandom_range(MaxPat + 1, 63);
        default: new_len = $urandom_range(1, 8);
      endcase
      write_len(new_len);
      load_pattern((new_len > MaxPat) ? MaxPat : new_len);
      // Once, hold the result side long enough for the input to back up.
      if (phase == 0) begin
        @(negedge clk_i);
        hold_asks++;
      end
      repeat ($urandom_range(6, 14)) send_name();
      drain();
      phase++;
    end

    if (err_count == 0) $display("PASS star_glob_matcher_top");
    else $display("FAIL star_glob_matcher_top");
    $finish;
  end

endmodule

FILE: files.f
design/sgm_pkg.sv
design/sgm_store.sv
design/sgm_nfa.sv
design/star_glob_matcher_top.sv
sim/tb_star_glob_matcher_top.sv
